### rtl/mvt4_pkg.sv
// Shared types and constants for the 4x4 matrix-vector transform unit.
package mvt4_pkg;

    localparam int DIM    = 4;
    localparam int IDX_W  = 2;
    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(DIM - 1);

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_XFORM = 1'b1
    } action_t;

    // per-lane control: element write and row issue
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_row;
        logic [DATA_W-1:0] wr_data;
        logic              issue;
        logic [IDX_W-1:0]  rd_row;
    } lane_ctl_t;

    // tag that follows one row through the pipeline
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] row;
    } row_tag_t;

endpackage

### rtl/matrix_vector_transform_4x4_unit.sv
// Top level of the 4x4 matrix-vector transform unit in signed fixed point.
//
// Input channel (in_valid/in_ready): action 0 loads element_value into the
// matrix at row_index/col_index and gives no result; action 1 transforms
// the vector (vec_x..vec_w) by the matrix.
// Output channel (out_valid/out_ready): one transfer of out_x..out_w per
// transform, in input order.
// Four column lanes each hold one matrix column and one 32x32 multiplier.
// A transform is issued one row per cycle, rows 0 to 3 in order; the merge
// stage adds the four products, shifts out FRAC_BITS and saturates.
// The row sequencer issues every row over the shared lane multipliers, so a
// new load or transform is accepted no earlier than the last issue cycle of
// the previous transform. Each row passes the lane product registers and
// the merge pair-sum registers before the output register takes the result.
// Reset clears the matrix to zero and empties the pipeline.
// When the receiver stalls the finished result holds in the output
// register and one more in the assembly buffer; input stalls once two
// transforms are outstanding.
module matrix_vector_transform_4x4_unit
    import mvt4_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     action,
    input  logic [IDX_W-1:0]         row_index,
    input  logic [IDX_W-1:0]         col_index,
    input  logic signed [DATA_W-1:0] element_value,
    input  logic signed [DATA_W-1:0] vec_x,
    input  logic signed [DATA_W-1:0] vec_y,
    input  logic signed [DATA_W-1:0] vec_z,
    input  logic signed [DATA_W-1:0] vec_w,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] out_x,
    output logic signed [DATA_W-1:0] out_y,
    output logic signed [DATA_W-1:0] out_z,
    output logic signed [DATA_W-1:0] out_w
);

    // issue sequencer
    logic                     busy_reg;
    logic                     busy_next;
    logic [IDX_W-1:0]         row_reg;
    logic [IDX_W-1:0]         row_next;
    logic signed [DATA_W-1:0] vec_reg [DIM];

    // transforms accepted and not yet delivered (at most two)
    logic [1:0]               cnt_reg;
    logic [1:0]               cnt_next;

    logic                     in_fire;
    logic                     out_fire;
    logic                     load_fire;
    logic                     xform_fire;
    logic                     issue_free;

    lane_ctl_t                lane_ctl [DIM];
    logic signed [PROD_W-1:0] prod [DIM];
    row_tag_t                 tag1_reg;
    row_tag_t                 tag_res;
    logic signed [DATA_W-1:0] row_res;

    // result assembly: rows 0..2 wait here, row 3 only when output is busy
    logic signed [DATA_W-1:0] asm_reg [DIM];
    logic                     asm_full_reg;
    logic                     out_valid_reg;
    logic                     out_free;
    logic                     last_in;
    logic                     move_asm;
    logic                     move_last;

    assign issue_free = !busy_reg || (row_reg == LAST_ROW);
    assign in_ready   = issue_free && (cnt_reg < 2'd2);
    assign in_fire    = in_valid && in_ready;
    assign load_fire  = in_fire && (action_t'(action) == ACT_LOAD);
    assign xform_fire = in_fire && (action_t'(action) == ACT_XFORM);
    assign out_fire   = out_valid_reg && out_ready;

    always_comb
    begin
        busy_next = busy_reg;
        row_next  = row_reg;
        if (xform_fire)
        begin
            busy_next = 1'b1;
            row_next  = '0;
        end
        else if (busy_reg)
        begin
            if (row_reg == LAST_ROW)
            begin
                busy_next = 1'b0;
            end
            row_next = row_reg + 1'b1;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, xform_fire} - {1'b0, out_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
            cnt_reg  <= '0;
            tag1_reg <= '0;
        end
        else
        begin
            busy_reg       <= busy_next;
            row_reg        <= row_next;
            cnt_reg        <= cnt_next;
            tag1_reg.valid <= busy_reg;
            tag1_reg.row   <= row_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (xform_fire)
        begin
            vec_reg[0] <= vec_x;
            vec_reg[1] <= vec_y;
            vec_reg[2] <= vec_z;
            vec_reg[3] <= vec_w;
        end
    end

    // column lanes
    for (genvar j = 0; j < DIM; j++)
    begin : g_lane
        always_comb
        begin
            lane_ctl[j].wr_en   = load_fire && (col_index == IDX_W'(j));
            lane_ctl[j].wr_row  = row_index;
            lane_ctl[j].wr_data = element_value;
            lane_ctl[j].issue   = busy_reg;
            lane_ctl[j].rd_row  = row_reg;
        end

        mvt4_lane u_lane
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (lane_ctl[j]),
            .vec_elem (vec_reg[j]),
            .prod     (prod[j])
        );
    end

    mvt4_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag1_reg),
        .prod    (prod),
        .tag_out (tag_res),
        .result  (row_res)
    );

    // output side
    assign out_free  = !out_valid_reg || out_ready;
    assign last_in   = tag_res.valid && (tag_res.row == LAST_ROW);
    assign move_last = last_in && out_free;
    assign move_asm  = asm_full_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            asm_full_reg  <= 1'b0;
        end
        else
        begin
            if (move_last || move_asm)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (last_in && !out_free)
            begin
                asm_full_reg <= 1'b1;
            end
            else if (move_asm)
            begin
                asm_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_res.valid && !move_last)
        begin
            asm_reg[tag_res.row] <= row_res;
        end

        if (move_last)
        begin
            out_x <= asm_reg[0];
            out_y <= asm_reg[1];
            out_z <= asm_reg[2];
            out_w <= row_res;
        end
        else if (move_asm)
        begin
            out_x <= asm_reg[0];
            out_y <= asm_reg[1];
            out_z <= asm_reg[2];
            out_w <= asm_reg[3];
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/mvt4_lane.sv
// One column lane: holds one matrix column and multiplies it by one vector element.
module mvt4_lane
    import mvt4_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lane_ctl_t                ctl,
    input  logic signed [DATA_W-1:0] vec_elem,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [DATA_W-1:0] col_reg [DIM];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DATA_W-1:0] elem;

    assign elem = col_reg[ctl.rd_row];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIM; i++)
            begin
                col_reg[i] <= '0;
            end
        end
        else if (ctl.wr_en)
        begin
            col_reg[ctl.wr_row] <= $signed(ctl.wr_data);
        end
    end

    // read happens before a same-cycle write lands
    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            prod_reg <= PROD_W'(elem) * PROD_W'(vec_elem);
        end
    end

    assign prod = prod_reg;

endmodule

### rtl/mvt4_merge.sv
// Merge stage: sums the four lane products, truncates the fraction and saturates.
module mvt4_merge
    import mvt4_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  row_tag_t                 tag_in,
    input  logic signed [PROD_W-1:0] prod [DIM],
    output row_tag_t                 tag_out,
    output logic signed [DATA_W-1:0] result
);

    localparam int HI_W = SUM_W - (DATA_W - 1);

    logic signed [PAIR_W-1:0] sum01_reg;
    logic signed [PAIR_W-1:0] sum23_reg;
    row_tag_t                 tag_reg;
    logic signed [SUM_W-1:0]  total;
    logic signed [SUM_W-1:0]  shifted;
    logic                     ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_in.valid)
        begin
            sum01_reg <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
            sum23_reg <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
        end
    end

    assign total   = SUM_W'(sum01_reg) + SUM_W'(sum23_reg);
    assign shifted = total >>> FRAC_BITS;
    // overflow when the bits above bit 31 are not a pure sign extension
    assign ovf     = |(shifted[SUM_W-1:DATA_W-1] ^ {HI_W{shifted[SUM_W-1]}});

    always_comb
    begin
        if (!ovf)
        begin
            result = shifted[DATA_W-1:0];
        end
        else if (shifted[SUM_W-1])
        begin
            result = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign tag_out = tag_reg;

endmodule
